>>> src/mcst_pkg.sv
// Shared types and codes for the timer slot array.
package mcst_pkg;

  localparam int OpW   = 2;
  localparam int SlotW = 4;
  localparam int TimeW = 32;
  localparam int KindW = 2;

  typedef enum logic [OpW-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_OK    = 2'd0,
    KIND_INVAL = 2'd1,
    KIND_FIRE  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [TimeW-1:0] target;
    logic [TimeW-1:0] period;
    logic             mode;
  } slot_entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [SlotW-1:0] slot;
    logic             last;
  } result_t;

endpackage

>>> src/mcst_in_if.sv
// Command channel: start, stop and tick items.
interface mcst_in_if import mcst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [SlotW-1:0] timer_slot;
  logic [TimeW-1:0] period;
  logic             periodic;

  modport source (output valid, op, timer_slot, period, periodic, input ready);
  modport sink   (input valid, op, timer_slot, period, periodic, output ready);
endinterface

>>> src/mcst_out_if.sv
// Result channel: status and fire results.
interface mcst_out_if import mcst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [SlotW-1:0] which_timer;
  logic             last;

  modport source (output valid, kind, which_timer, last, input ready);
  modport sink   (input valid, kind, which_timer, last, output ready);
endinterface

>>> src/mcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mcst_out_reg.sv
// Output register between the scan logic and the result channel.
module mcst_out_reg import mcst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    can_load_o,
  mcst_out_if.source out_o
);

  logic    valid_q;
  result_t res_q;

  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kind        = res_q.kind;
  assign out_o.which_timer = res_q.slot;
  assign out_o.last        = res_q.last;

endmodule

>>> src/multi_channel_software_timer.sv
// Timer slot array: command handling, slot scan and slot RAM.
// Start/stop: one status result after the transfer; the block is busy
//   until the status is loaded into the output register.
// Tick: the scan reads min(TIMER_COUNT,16) slots from the slot RAM, one slot per cycle
//   while the output does not stall; one item is worked at a time.
// Reset clears system time and all armed bits; slot RAM contents are not cleared.
module multi_channel_software_timer import mcst_pkg::*; #(
  parameter int TIMER_COUNT = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mcst_in_if.sink    in_i,
  mcst_out_if.source out_o
);

  localparam int SlotLimit = (TIMER_COUNT < 16) ? TIMER_COUNT : 16;
  localparam int AddrW     = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CntW      = $clog2(SlotLimit + 1);
  localparam int EntryW    = $bits(slot_entry_t);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PUSH  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [TimeW-1:0]       time_q, time_d;
  logic [TIMER_COUNT-1:0] armed_q, armed_d;
  logic [CntW-1:0]        scan_q, scan_d;
  logic                   ev_valid_q, ev_valid_d;
  logic [AddrW-1:0]       ev_idx_q, ev_idx_d;
  logic                   hold_valid_q, hold_valid_d;
  logic [AddrW-1:0]       hold_idx_q, hold_idx_d;
  result_t                status_q, status_d;

  logic              in_fire;
  logic              slot_ok;
  logic [AddrW-1:0]  in_addr;
  logic              start_ok;
  logic              issue_more;
  logic              fire;
  logic              stall;
  logic              can_load;
  logic              push;
  result_t           push_res;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  slot_entry_t       ram_wentry;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  slot_entry_t       rd_entry;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_ok    = {1'b0, in_i.timer_slot} < 5'(SlotLimit);
  assign in_addr    = AddrW'(in_i.timer_slot);
  assign start_ok   = slot_ok && (in_i.period != '0);

  assign rd_entry   = slot_entry_t'(ram_rdata);
  assign issue_more = (scan_q != CntW'(SlotLimit));
  assign fire       = (state_q == ST_SCAN) && ev_valid_q && armed_q[ev_idx_q] &&
                      (time_q >= rd_entry.target);
  // a second fire needs the held one to go out first
  assign stall      = fire && hold_valid_q && !can_load;
  assign ram_raddr  = stall ? ev_idx_q : AddrW'(scan_q);

  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    armed_d      = armed_q;
    scan_d       = scan_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    hold_valid_d = hold_valid_q;
    hold_idx_d   = hold_idx_q;
    status_d     = status_q;
    push         = 1'b0;
    push_res     = status_q;
    ram_we       = 1'b0;
    ram_waddr    = ev_idx_q;
    ram_wentry   = '{target: time_q + rd_entry.period, period: rd_entry.period,
                     mode: rd_entry.mode};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          status_d.slot = in_i.timer_slot;
          status_d.last = 1'b1;
          if (in_i.op == OP_START) begin
            status_d.kind = start_ok ? KIND_OK : KIND_INVAL;
            if (start_ok) begin
              ram_we     = 1'b1;
              ram_waddr  = in_addr;
              ram_wentry = '{target: time_q + in_i.period, period: in_i.period,
                             mode: in_i.periodic};
              armed_d[in_addr] = 1'b1;
            end
            state_d = ST_PUSH;
          end else if (in_i.op == OP_STOP) begin
            status_d.kind = slot_ok ? KIND_OK : KIND_INVAL;
            if (slot_ok) begin
              armed_d[in_addr] = 1'b0;
            end
            state_d = ST_PUSH;
          end else if (in_i.op == OP_TICK) begin
            time_d       = time_q + 1'b1;
            scan_d       = '0;
            ev_valid_d   = 1'b0;
            hold_valid_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_PUSH: begin
        if (can_load) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (fire) begin
            if (hold_valid_q) begin
              push     = 1'b1;
              push_res = '{kind: KIND_FIRE, slot: SlotW'(hold_idx_q), last: 1'b0};
            end
            hold_valid_d = 1'b1;
            hold_idx_d   = ev_idx_q;
            if (rd_entry.mode) begin
              ram_we = 1'b1;
            end else begin
              armed_d[ev_idx_q] = 1'b0;
            end
          end
          if (issue_more) begin
            ev_valid_d = 1'b1;
            ev_idx_d   = AddrW'(scan_q);
            scan_d     = scan_q + 1'b1;
          end else begin
            ev_valid_d = 1'b0;
            if (!ev_valid_q) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_load) begin
          push         = 1'b1;
          push_res     = '{kind: KIND_FIRE, slot: SlotW'(hold_idx_q), last: 1'b1};
          hold_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_q       <= '0;
      armed_q      <= '0;
      scan_q       <= '0;
      ev_valid_q   <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      armed_q      <= armed_d;
      scan_q       <= scan_d;
      ev_valid_q   <= ev_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q   <= ev_idx_d;
    hold_idx_q <= hold_idx_d;
    status_q   <= status_d;
  end

  mcst_ram #(
    .Width (EntryW),
    .Depth (TIMER_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mcst_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (push_res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  a_tick_advances_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.op == OP_TICK) |=> time_q == $past(time_q) + 32'd1)
    else $error("system time did not advance on tick");

  a_hold_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
    else $error("held fire result outside of a tick");

  a_stall_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (ev_valid_q && $stable(ev_idx_q) && state_q == ST_SCAN))
    else $error("scan moved on during an output stall");

endmodule
